// ===== rtl/core/pam_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pam_pkg;
  localparam int MaxPointsDef = 256;
  localparam int CoordW       = 32;
  localparam int LabelW       = 8;
  localparam int DiffW        = CoordW + 1;
  localparam int RadW         = 2 * DiffW + 2;
  localparam int RootW        = RadW / 2;
  localparam int TFrac        = 24;
  localparam int TW           = TFrac + 1;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [LabelW-1:0]        label;
  } point_t;

  // unit handshake between the sequencer and an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;
endpackage
`default_nettype wire

// ===== rtl/core/pam_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pam_store import pam_pkg::*; #(
  parameter int MAX_POINTS = MaxPointsDef,
  parameter int AW         = $clog2(MAX_POINTS),
  parameter int ARC_W      = 34 + $clog2(MAX_POINTS)
) (
  input  wire              clk,
  input  wire              pt_we,
  input  wire              arc_we,
  input  wire [AW-1:0]     waddr,
  input  wire point_t      pt_wdata,
  input  wire [ARC_W-1:0]  arc_wdata,
  input  wire [AW-1:0]     raddr,
  output point_t           pt_rdata,
  output logic [ARC_W-1:0] arc_rdata
);
  point_t           pt_mem  [MAX_POINTS];
  logic [ARC_W-1:0] arc_mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[waddr] <= pt_wdata;
    end
    if (arc_we) begin
      arc_mem[waddr] <= arc_wdata;
    end
    pt_rdata  <= pt_mem[raddr];
    arc_rdata <= arc_mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/pam_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pam_sqrt import pam_pkg::*; (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  input  wire [RadW-1:0]   radicand,
  output logic [RootW-1:0] root,
  output unit_status_t     status
);
  localparam int RemW = RootW + 4;
  localparam int CW   = $clog2(RootW + 1);

  logic [RadW-1:0] rad;
  logic [RemW-1:0] rem;
  logic [CW-1:0]   cnt;
  logic [RemW-1:0] rem_sh;
  logic [RemW-1:0] trial;

  assign rem_sh = {rem[RemW-3:0], rad[RadW-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        rad         <= radicand;
        rem         <= '0;
        root        <= '0;
        cnt         <= CW'(RootW);
        status.busy <= 1'b1;
      end else if (status.busy) begin
        // one root bit per cycle
        rad <= {rad[RadW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[RootW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[RootW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/pam_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pam_div import pam_pkg::*; #(
  parameter int NUM_W = 67,
  parameter int DEN_W = 43
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  input  wire [NUM_W-1:0]  numer,
  input  wire [DEN_W-1:0]  denom,
  output logic [NUM_W-1:0] quot,
  output unit_status_t     status
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   rem;
  logic [DEN_W:0]   rem_sh;
  logic [CW-1:0]    cnt;

  assign rem_sh = {rem[DEN_W-1:0], num[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        num         <= numer;
        den         <= denom;
        rem         <= '0;
        quot        <= '0;
        cnt         <= CW'(NUM_W);
        status.busy <= 1'b1;
      end else if (status.busy) begin
        // restoring division, one quotient bit per cycle
        num <= {num[NUM_W-2:0], 1'b0};
        if (rem_sh >= {1'b0, den}) begin
          rem  <= rem_sh - {1'b0, den};
          quot <= {quot[NUM_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          quot <= {quot[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/polyline_arc_midpoint_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Arc-length midpoint of a 3D polyline. Points arrive one item each (Q21.10
// metres) and are written to an on-chip point memory together with the running
// arc length; the item flagged last_point returns one result item: the point
// halfway along the total length, interpolated inside the segment that holds
// it, with the label of that segment's start point. An empty polyline gives the
// zero point, a single point gives itself, and points beyond MAX_POINTS are
// dropped and reported through overflowed. A new item is taken only in idle,
// once the previous one is done. A point that adds a segment waits for the
// bit-serial square root (34-bit root) behind the squaring of the three
// coordinate differences. A last item then adds the midpoint search, reading
// one stored entry at a time up to the halfway point through the single memory
// read port, then the segment reads, the 67-bit serial divider and the
// interpolation, skipping the divider when the fraction is zero; the result
// waits while the previous result item is still held at the output. No clearing
// pass is needed: only entries below the point count are ever used.
module polyline_arc_midpoint_top import pam_pkg::*; #(
  parameter int MAX_POINTS = MaxPointsDef
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire                     has_point,
  input  wire signed [CoordW-1:0] point_x,
  input  wire signed [CoordW-1:0] point_y,
  input  wire signed [CoordW-1:0] point_z,
  input  wire [LabelW-1:0]        point_label,
  input  wire                     last_point,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic signed [CoordW-1:0] center_x,
  output logic signed [CoordW-1:0] center_y,
  output logic signed [CoordW-1:0] center_z,
  output logic [LabelW-1:0]       center_label,
  output logic                    overflowed
);
  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int ARC_W = 34 + $clog2(MAX_POINTS);
  localparam int NUM_W = ARC_W + 1 + TFrac;
  localparam int DEN_W = ARC_W + 1;
  localparam int PW    = DiffW + TW + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_POST = 4'd4;
  localparam logic [3:0] S_SRCH = 4'd5;
  localparam logic [3:0] S_SCMP = 4'd6;
  localparam logic [3:0] S_RA0  = 4'd7;
  localparam logic [3:0] S_RA1  = 4'd8;
  localparam logic [3:0] S_RA2  = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_LERP = 4'd11;
  localparam logic [3:0] S_EMIT = 4'd12;
  localparam logic [3:0] S_RA3  = 4'd13;

  logic [3:0]       state;
  point_t           cur;
  logic             cur_has;
  logic             cur_last;
  point_t           prev;
  logic [ARC_W-1:0] total;
  logic [CNT_W-1:0] count;
  logic             ovf;
  logic [1:0]       step;
  logic [RadW-1:0]  sq_acc;
  logic [2*DiffW-1:0] sq_prod;
  logic [AW-1:0]    sidx;
  logic [AW-1:0]    idx;
  logic [AW-1:0]    raddr;
  logic             single;
  logic [ARC_W-1:0] start_arc;
  point_t           p0;
  point_t           p1;
  logic [TW-1:0]    t;
  logic signed [PW-1:0] lprod;
  point_t           res;

  // memory ports
  logic             pt_we;
  logic             arc_we;
  logic [ARC_W-1:0] arc_wdata;
  point_t           pt_rdata;
  logic [ARC_W-1:0] arc_rdata;

  // arithmetic units
  logic             sqrt_start;
  logic [RootW-1:0] root;
  unit_status_t     sqrt_st;
  logic             div_start;
  logic [NUM_W-1:0] numer;
  logic [DEN_W-1:0] denom;
  logic [NUM_W-1:0] quot;
  unit_status_t     div_st;

  logic signed [DiffW-1:0] dsel;
  logic [DiffW-1:0]        dabs;
  logic [ARC_W-1:0]        len;
  logic signed [DiffW-1:0] ldiff;
  logic signed [CoordW-1:0] lp0;
  logic signed [CoordW-1:0] lsum;
  logic signed [PW-1:0]     lbiased;

  assign in_ready = (state == S_IDLE);

  // difference of the selected coordinate for squaring
  always_comb begin
    case (step)
      2'd0:    dsel = DiffW'(cur.x) - DiffW'(prev.x);
      2'd1:    dsel = DiffW'(cur.y) - DiffW'(prev.y);
      default: dsel = DiffW'(cur.z) - DiffW'(prev.z);
    endcase
    dabs = dsel[DiffW-1] ? DiffW'(-dsel) : DiffW'(dsel);
  end

  // interpolation difference for the selected coordinate
  always_comb begin
    case (step)
      2'd0:    ldiff = DiffW'(p1.x) - DiffW'(p0.x);
      2'd1:    ldiff = DiffW'(p1.y) - DiffW'(p0.y);
      default: ldiff = DiffW'(p1.z) - DiffW'(p0.z);
    endcase
  end

  // the coordinate finished this cycle belongs to the step before
  always_comb begin
    case (step)
      2'd1:    lp0 = p0.x;
      2'd2:    lp0 = p0.y;
      default: lp0 = p0.z;
    endcase
  end

  assign lbiased = lprod + PW'(1 << (TFrac - 1));
  assign lsum    = lp0 + CoordW'(lbiased >>> TFrac);
  assign len     = arc_rdata - start_arc;

  assign sqrt_start = (state == S_SQ) && (step == 2'd3);
  assign pt_we      = (state == S_LOAD) && cur_has && (count < CNT_W'(MAX_POINTS));
  assign arc_we     = (pt_we && (count == '0)) || ((state == S_SQRT) && sqrt_st.done);
  assign arc_wdata  = (state == S_SQRT) ? total + ARC_W'(root) : '0;
  assign div_start  = (state == S_RA3) && !single && (len != '0)
                      && ({1'b0, total} >= {start_arc, 1'b0});
  assign numer      = NUM_W'({1'b0, total} - {start_arc, 1'b0}) << TFrac;
  assign denom      = {len, 1'b0};

  pam_store #(.MAX_POINTS(MAX_POINTS), .AW(AW), .ARC_W(ARC_W)) u_store (
    .clk      (clk),
    .pt_we    (pt_we),
    .arc_we   (arc_we),
    .waddr    (count[AW-1:0]),
    .pt_wdata (cur),
    .arc_wdata(arc_wdata),
    .raddr    (raddr),
    .pt_rdata (pt_rdata),
    .arc_rdata(arc_rdata)
  );

  pam_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sqrt_start),
    .radicand(sq_acc + RadW'(sq_prod)),
    .root    (root),
    .status  (sqrt_st)
  );

  pam_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (numer),
    .denom (denom),
    .quot  (quot),
    .status(div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      // drop the held result once taken, unless a new one replaces it
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur.x     <= point_x;
            cur.y     <= point_y;
            cur.z     <= point_z;
            cur.label <= point_label;
            cur_has   <= has_point;
            cur_last  <= last_point;
            state     <= S_LOAD;
          end
        end
        S_LOAD: begin
          step <= '0;
          if (pt_we && (count == '0)) begin
            // first point: length zero
            prev  <= cur;
            total <= '0;
            count <= count + 1'b1;
            state <= S_POST;
          end else if (pt_we) begin
            sq_acc <= '0;
            state  <= S_SQ;
          end else begin
            if (cur_has) begin
              ovf <= 1'b1;
            end
            state <= S_POST;
          end
        end
        S_SQ: begin
          // square one coordinate, accumulate the previous one
          sq_prod <= dabs * dabs;
          if (step != 2'd0) begin
            sq_acc <= sq_acc + RadW'(sq_prod);
          end
          if (step == 2'd3) begin
            state <= S_SQRT;
          end
          step <= step + 1'b1;
        end
        S_SQRT: begin
          if (sqrt_st.done) begin
            prev  <= cur;
            total <= arc_wdata;
            count <= count + 1'b1;
            state <= S_POST;
          end
        end
        S_POST: begin
          single <= (count == CNT_W'(1));
          if (!cur_last) begin
            state <= S_IDLE;
          end else if (count == '0) begin
            res   <= '0;
            state <= S_EMIT;
          end else if (count == CNT_W'(1)) begin
            idx    <= '0;
            state  <= S_RA0;
          end else begin
            sidx  <= '0;
            raddr <= '0;
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          // hold while the addressed entry is read
          state <= S_SCMP;
        end
        S_SCMP: begin
          // stop at the first entry at or above half the total, or at the last entry
          if (({arc_rdata, 1'b0} >= {1'b0, total})
              || (CNT_W'(sidx) + 1'b1 == count)) begin
            idx   <= (sidx == '0) ? '0 : sidx - 1'b1;
            state <= S_RA0;
          end else begin
            sidx  <= sidx + 1'b1;
            raddr <= sidx + 1'b1;
            state <= S_SRCH;
          end
        end
        S_RA0: begin
          raddr <= idx;
          state <= S_RA1;
        end
        S_RA1: begin
          raddr <= idx + 1'b1;
          state <= S_RA2;
        end
        S_RA2: begin
          // segment start arrives
          start_arc <= arc_rdata;
          p0        <= pt_rdata;
          state     <= S_RA3;
        end
        S_RA3: begin
          // segment end arrives: divide, or skip with a zero fraction
          p1   <= single ? p0 : pt_rdata;
          step <= '0;
          if (single || len == '0 || ({1'b0, total} < {start_arc, 1'b0})) begin
            t     <= '0;
            state <= S_LERP;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            t     <= (quot > NUM_W'(1 << TFrac)) ? TW'(1 << TFrac) : quot[TW-1:0];
            step  <= '0;
            state <= S_LERP;
          end
        end
        S_LERP: begin
          lprod <= PW'(ldiff) * $signed({1'b0, t});
          case (step)
            2'd1:    res.x <= lsum;
            2'd2:    res.y <= lsum;
            2'd3:    res.z <= lsum;
            default: ;
          endcase
          if (step == 2'd3) begin
            res.label <= p0.label;
            state     <= S_EMIT;
          end
          step <= step + 1'b1;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            center_x     <= res.x;
            center_y     <= res.y;
            center_z     <= res.z;
            center_label <= res.label;
            overflowed   <= ovf;
            count        <= '0;
            ovf          <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond capacity");
  a_sqrt_state: assert property (@(posedge clk) disable iff (rst)
    sqrt_st.busy |-> state == S_SQRT)
    else $error("square root busy outside its state");
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_st.busy |-> state == S_DIV)
    else $error("divider busy outside its state");
  a_emit_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && (!out_valid || out_ready)) |=> (count == '0 && !ovf))
    else $error("state not cleared after result");
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> count == CNT_W'(MAX_POINTS))
    else $error("overflow flagged below capacity");
`endif
endmodule
`default_nettype wire
